// ----- rtl/ercp_pkg.sv -----
// ----------------------------------------------------------------------------
// ercp_pkg
// Shared types, reset values and the quadrature step decoder for the
// encoder RGB control panel.
// ----------------------------------------------------------------------------
package ercp_pkg;

  localparam int NumLedsDefault = 24;

  localparam int LevelMax  = 255;
  localparam int DelayMin  = 1;
  localparam int DelayMax  = 1000;
  localparam int DelayStep = 10;

  localparam int LitReset       = 1;
  localparam int RedReset       = 50;
  localparam int GreenReset     = 0;
  localparam int BlueReset      = 0;
  localparam int IntensityReset = 20;
  localparam int DelayReset     = 200;

  typedef enum logic [1:0] {
    CH_RED   = 2'd0,
    CH_GREEN = 2'd1,
    CH_BLUE  = 2'd2
  } channel_e;

  typedef struct packed {
    logic [1:0]        prev;
    logic signed [2:0] steps;
    logic signed [1:0] det;
  } enc_dec_t;

  // Gray-code direction: 0->1->3->2->0 is +1, reverse is -1, else 0.
  function automatic logic signed [1:0] step_dir(logic [1:0] prev, logic [1:0] cur);
    logic signed [1:0] dir;
    unique case ({prev, cur})
      4'b0001, 4'b0111, 4'b1000, 4'b1110: dir = 2'sd1;
      4'b0010, 4'b0100, 4'b1011, 4'b1101: dir = -2'sd1;
      default:                            dir = 2'sd0;
    endcase
    return dir;
  endfunction

  function automatic enc_dec_t decode(logic [1:0] prev, logic signed [2:0] steps,
                                      logic [1:0] cur);
    enc_dec_t          r;
    logic signed [1:0] dir;
    logic signed [2:0] s;
    dir     = step_dir(prev, cur);
    s       = steps + {dir[1], dir};
    r.prev  = prev;
    r.steps = steps;
    r.det   = 2'sd0;
    if (cur != prev) begin
      r.prev  = cur;
      r.steps = s;
      if (s >= 3'sd2) begin
        r.steps = 3'sd0;
        r.det   = 2'sd1;
      end else if (s <= -3'sd2) begin
        r.steps = 3'sd0;
        r.det   = -2'sd1;
      end
    end
    return r;
  endfunction

  function automatic logic [7:0] level_step(logic [7:0] lvl, logic signed [1:0] det);
    logic [7:0] r;
    r = lvl;
    if (det == 2'sd1 && lvl != 8'(LevelMax)) begin
      r = lvl + 8'd1;
    end else if (det == -2'sd1 && lvl != 8'd0) begin
      r = lvl - 8'd1;
    end
    return r;
  endfunction

endpackage

// ----- rtl/encoder_rgb_control_panel.sv -----
// ----------------------------------------------------------------------------
// encoder_rgb_control_panel
// Decodes pin samples of three quadrature encoders and two buttons into
// LED count, color levels, rainbow mode, intensity and delay settings.
// ----------------------------------------------------------------------------
//  channel   dir  beat contents
//  s_axis    in   one pin sample (8 bits)
//  m_axis    out  panel settings after that sample (one beat per sample)
//
//  One result beat per input beat: each sample passes the input register,
//  then is decoded and updated into the state and result registers.
//  Sustained rate is one beat per cycle; the result register is the only
//  limit, and a stalled result stops the input register behind it.
//  Reset restores the power-up settings and clears both valid flags.
// ----------------------------------------------------------------------------
module encoder_rgb_control_panel #(
  parameter int NUM_LEDS = ercp_pkg::NumLedsDefault,
  localparam int LitW    = $clog2(NUM_LEDS + 1),
  localparam int FieldW  = LitW + 45,
  localparam int OutW    = ((FieldW + 7) / 8) * 8
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            s_axis_tvalid,
  output logic            s_axis_tready,
  // enc1_a, enc1_b, enc1_sw, enc2_a, enc2_b, enc3_a, enc3_b, enc3_sw
  input  logic [7:0]      s_axis_tdata,
  output logic            m_axis_tvalid,
  input  logic            m_axis_tready,
  // lit_count, red_level, green_level, blue_level, channel_sel, rainbow_on,
  // intensity, delay_ms, zero pad
  output logic [OutW-1:0] m_axis_tdata
);

  logic            in_valid_q;
  logic [7:0]      in_data_q;
  logic            out_valid_q;
  logic [OutW-1:0] out_data_q, out_data_d;
  logic            out_free, adv;

  logic              first_q;
  logic [1:0]        e1_prev_q, e2_prev_q, e3_prev_q;
  logic signed [2:0] e1_steps_q, e2_steps_q, e3_steps_q;
  logic              btn1_q, btn3_q;
  logic [LitW-1:0]   lit_q, lit_d;
  logic [7:0]        red_q, red_d, green_q, green_d, blue_q, blue_d;
  logic [7:0]        intens_q, intens_d;
  logic [1:0]        chan_q, chan_d;
  logic              rainbow_q, rainbow_d;
  logic [9:0]        delay_q, delay_d;

  logic [1:0]         e1, e2, e3, p1, p3;
  logic               sw1, sw3;
  ercp_pkg::enc_dec_t d1, d2, d3;

  assign out_free      = !out_valid_q || m_axis_tready;
  assign adv           = in_valid_q && out_free;
  assign s_axis_tready = !in_valid_q || out_free;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  assign e1  = {in_data_q[1], in_data_q[0]};
  assign sw1 = in_data_q[2];
  assign e2  = {in_data_q[4], in_data_q[3]};
  assign e3  = {in_data_q[6], in_data_q[5]};
  assign sw3 = in_data_q[7];
  assign p1  = first_q ? e1_prev_q : e1;
  assign p3  = first_q ? e3_prev_q : e3;

  always_comb begin
    d2 = ercp_pkg::decode(e2_prev_q, e2_steps_q, e2);
    d1 = ercp_pkg::decode(p1, e1_steps_q, e1);
    d3 = ercp_pkg::decode(p3, e3_steps_q, e3);
    if (!rainbow_q) begin
      d3.prev  = p3;
      d3.steps = e3_steps_q;
      d3.det   = 2'sd0;
    end

    lit_d = lit_q;
    if (d2.det == 2'sd1 && lit_q < LitW'(NUM_LEDS)) begin
      lit_d = lit_q + LitW'(1);
    end else if (d2.det == -2'sd1 && lit_q != '0) begin
      lit_d = lit_q - LitW'(1);
    end

    red_d    = red_q;
    green_d  = green_q;
    blue_d   = blue_q;
    intens_d = intens_q;
    if (rainbow_q) begin
      intens_d = ercp_pkg::level_step(intens_q, d1.det);
    end else if (chan_q == ercp_pkg::CH_RED) begin
      red_d = ercp_pkg::level_step(red_q, d1.det);
    end else if (chan_q == ercp_pkg::CH_GREEN) begin
      green_d = ercp_pkg::level_step(green_q, d1.det);
    end else begin
      blue_d = ercp_pkg::level_step(blue_q, d1.det);
    end

    chan_d = chan_q;
    if (btn1_q && !sw1) begin
      chan_d = (chan_q >= ercp_pkg::CH_BLUE) ? ercp_pkg::CH_RED : chan_q + 2'd1;
    end

    delay_d = delay_q;
    if (d3.det == 2'sd1) begin
      delay_d = (delay_q <= 10'(ercp_pkg::DelayMin + ercp_pkg::DelayStep - 1)) ?
                10'(ercp_pkg::DelayMin) : delay_q - 10'(ercp_pkg::DelayStep);
    end else if (d3.det == -2'sd1) begin
      delay_d = (delay_q >= 10'(ercp_pkg::DelayMax - ercp_pkg::DelayStep)) ?
                10'(ercp_pkg::DelayMax) : delay_q + 10'(ercp_pkg::DelayStep);
    end

    rainbow_d = rainbow_q ^ (btn3_q && !sw3);

    out_data_d = '0;
    out_data_d[FieldW-1:0] = {delay_d, intens_d, rainbow_d, chan_d,
                              blue_d, green_d, red_d, lit_d};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_data_q <= s_axis_tdata;
    end
    if (adv) begin
      out_data_q <= out_data_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      first_q     <= 1'b0;
      e1_prev_q   <= '0;
      e2_prev_q   <= '0;
      e3_prev_q   <= '0;
      e1_steps_q  <= '0;
      e2_steps_q  <= '0;
      e3_steps_q  <= '0;
      btn1_q      <= 1'b1;
      btn3_q      <= 1'b1;
      lit_q       <= LitW'(ercp_pkg::LitReset);
      red_q       <= 8'(ercp_pkg::RedReset);
      green_q     <= 8'(ercp_pkg::GreenReset);
      blue_q      <= 8'(ercp_pkg::BlueReset);
      chan_q      <= ercp_pkg::CH_RED;
      rainbow_q   <= 1'b0;
      intens_q    <= 8'(ercp_pkg::IntensityReset);
      delay_q     <= 10'(ercp_pkg::DelayReset);
    end else begin
      if (out_free) begin
        out_valid_q <= in_valid_q;
      end
      if (adv) begin
        first_q    <= 1'b1;
        e1_prev_q  <= d1.prev;
        e2_prev_q  <= d2.prev;
        e3_prev_q  <= d3.prev;
        e1_steps_q <= d1.steps;
        e2_steps_q <= d2.steps;
        e3_steps_q <= d3.steps;
        btn1_q     <= sw1;
        btn3_q     <= sw3;
        lit_q      <= lit_d;
        red_q      <= red_d;
        green_q    <= green_d;
        blue_q     <= blue_d;
        chan_q     <= chan_d;
        rainbow_q  <= rainbow_d;
        intens_q   <= intens_d;
        delay_q    <= delay_d;
      end
    end
  end

  a_lit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lit_q <= LitW'(NUM_LEDS))
    else $error("lit count above LED count");

  a_delay_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    delay_q >= 10'(ercp_pkg::DelayMin) && delay_q <= 10'(ercp_pkg::DelayMax))
    else $error("delay out of range");

  a_chan_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    chan_q != 2'd3)
    else $error("channel select holds unused code");

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> s_axis_tready)
    else $error("input stalled with empty result register");

  a_state_on_adv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(rainbow_q) |-> $past(adv))
    else $error("rainbow mode changed without a beat");

endmodule
